// ----- hdl/adjacency_matrix_store_assert.svh -----
// Assertion macros for the adjacency matrix store.
// Each expects signals named clk and rst in the enclosing module.
`ifndef ADJACENCY_MATRIX_STORE_ASSERT_SVH
`define ADJACENCY_MATRIX_STORE_ASSERT_SVH

// Same-cycle implication.
`define AMS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ams_pkg.sv -----
`default_nettype none
package ams_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int ADDR_W       = 2 * VIDX_W;
  localparam int DEPTH        = 2 ** ADDR_W;
  localparam int WORD_W       = 32;
  localparam int VNUM_W       = 4;

  localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hBF80_0000;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_QUERY    = 3'd2,
    OP_LIST_NBR = 3'd3,
    OP_LIST_ALL = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_INVALID  = 3'd1,
    STS_SELF     = 3'd2,
    STS_PARALLEL = 3'd3,
    STS_NO_EDGE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    status_t             status;
    logic                adjacent;
    logic                found;
    logic [VNUM_W-1:0]   edge_source;
    logic [VNUM_W-1:0]   edge_dest;
    logic [WORD_W-1:0]   edge_weight;
    logic                last;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/adjacency_matrix_store.sv -----
// Directed weighted graph held as an adjacency matrix of 32-bit weight words.
// Input channel s_*: one operation per transfer (add, remove, query, list
// neighbors, list all edges, clear). Output channel m_*: one or more results
// per operation, the final one marked with m_tlast.
// vertex_count is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. Add,
// remove, query and clear are decided in ST_CHECK, which holds until the
// output register is free; their result is registered there. List operations
// step through the matrix one word per cycle, unless the receiver stalls, on
// the single RAM read port: a neighbor list scans the N entries of the source
// row and the full edge list all N*N entries, N the active vertex count.
// Each listed edge is held one step so that the final one can carry tlast.
// s_tready is high only while no operation is in progress; an input can be
// taken while the previous result still waits in the output register.
// When the receiver stalls, the sequencer holds at the next result to hand
// over and nothing is lost. Reset empties the matrix at once (per-entry
// valid bits), sets vertex_count to 8 and drops any pending result.
`default_nettype none
`include "adjacency_matrix_store_assert.svh"
module adjacency_matrix_store
  import ams_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operation[2:0], source[6:3], dest[10:7], weight[42:11], zero fill above
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], adjacent[3], found[4], edge_source[8:5], edge_dest[12:9],
  // edge_weight[44:13], zero fill above
  output logic [47:0]      m_tdata,
  output logic             m_tlast
);

  state_t state, state_next;

  logic [2:0]        op_q;
  logic [VNUM_W-1:0] src_q, dst_q;
  logic [WORD_W-1:0] wgt_q;
  logic [3:0]        vertex_count;

  logic [ADDR_W-1:0] rd_addr, addr_q;
  logic [VIDX_W-1:0] row_q, col_q, row_next, col_next;
  logic [WORD_W-1:0] rdata;
  logic [DEPTH-1:0]  valid;

  logic              pend_valid;
  logic [VNUM_W-1:0] pend_src, pend_dst;
  logic [WORD_W-1:0] pend_wgt;

  res_t out_q, emit_res;
  logic emit, out_free;
  logic ram_we, valid_set, valid_clr, clr_all, pend_load, pend_clear;

  logic [3:0]        n_act, n_m1;
  logic [VIDX_W-1:0] n_last;
  logic              src_ok, dst_ok, entry_full, scan_last, stall;
  logic [WORD_W-1:0] entry_word;
  logic [VNUM_W-1:0] in_src, in_dst, src_m1;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [VNUM_W-1:0] s,
                                                  input logic [VNUM_W-1:0] d);
    logic [VNUM_W-1:0] sm, dm;
    sm = s - 4'd1;
    dm = d - 4'd1;
    return {sm[VIDX_W-1:0], dm[VIDX_W-1:0]};
  endfunction

  ams_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_q),
    .wdata (wgt_q),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign in_src = s_tdata[6:3];
  assign in_dst = s_tdata[10:7];

  assign n_act  = (vertex_count > 4'(MAX_VERTICES)) ? 4'(MAX_VERTICES) : vertex_count;
  assign n_m1   = n_act - 4'd1;
  assign n_last = n_m1[VIDX_W-1:0];
  assign src_m1 = src_q - 4'd1;
  assign src_ok = (src_q >= 4'd1) && (src_q <= n_act);
  assign dst_ok = (dst_q >= 4'd1) && (dst_q <= n_act);

  // a never-written entry reads as empty
  assign entry_word = valid[addr_q] ? rdata : EMPTY_WORD;
  assign entry_full = (entry_word != EMPTY_WORD);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  assign scan_last = (op_q == OP_LIST_NBR) ? (col_q == n_last)
                                           : (row_q == n_last) && (col_q == n_last);
  assign stall = entry_full && pend_valid && !out_free;

  always_comb begin
    state_next = state;
    rd_addr    = addr_q;
    row_next   = row_q;
    col_next   = col_q;
    emit       = 1'b0;
    emit_res   = '0;
    ram_we     = 1'b0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    clr_all    = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          rd_addr    = cell_addr(in_src, in_dst);
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // hold without side effects until the output register is free
        if (out_free) begin
          emit_res.last = 1'b1;
          state_next    = ST_IDLE;
          case (op_q)
            OP_ADD: begin
              emit = 1'b1;
              if (!(src_ok && dst_ok)) begin
                emit_res.status = STS_INVALID;
              end else if (src_q == dst_q) begin
                emit_res.status = STS_SELF;
              end else if (entry_full) begin
                emit_res.status = STS_PARALLEL;
              end else begin
                ram_we    = 1'b1;
                valid_set = 1'b1;
              end
            end
            OP_REMOVE: begin
              emit = 1'b1;
              if (!(src_ok && dst_ok)) begin
                emit_res.status = STS_INVALID;
              end else if (!entry_full) begin
                emit_res.status = STS_NO_EDGE;
              end else begin
                valid_clr = 1'b1;
              end
            end
            OP_QUERY: begin
              emit = 1'b1;
              if (!(src_ok && dst_ok)) begin
                emit_res.status = STS_INVALID;
              end else begin
                emit_res.adjacent = entry_full;
              end
            end
            OP_LIST_NBR: begin
              if (!src_ok) begin
                emit            = 1'b1;
                emit_res.status = STS_INVALID;
              end else begin
                row_next   = src_m1[VIDX_W-1:0];
                col_next   = '0;
                rd_addr    = {row_next, col_next};
                state_next = ST_SCAN;
              end
            end
            OP_LIST_ALL: begin
              if (n_act == 4'd0) begin
                emit = 1'b1;
              end else begin
                row_next   = '0;
                col_next   = '0;
                rd_addr    = {row_next, col_next};
                state_next = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              emit    = 1'b1;
              clr_all = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (entry_full) begin
            pend_load = 1'b1;
            if (pend_valid) begin
              // a newer edge exists, so the held one is not the final result
              emit                 = 1'b1;
              emit_res.found       = 1'b1;
              emit_res.edge_source = pend_src;
              emit_res.edge_dest   = pend_dst;
              emit_res.edge_weight = pend_wgt;
            end
          end
          if (scan_last) begin
            state_next = ST_FLUSH;
          end else begin
            if (op_q == OP_LIST_ALL && col_q == n_last) begin
              col_next = '0;
              row_next = row_q + 1'b1;
            end else begin
              col_next = col_q + 1'b1;
            end
            rd_addr = {row_next, col_next};
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.last = 1'b1;
          if (pend_valid) begin
            emit_res.found       = 1'b1;
            emit_res.edge_source = pend_src;
            emit_res.edge_dest   = pend_dst;
            emit_res.edge_weight = pend_wgt;
          end
          pend_clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      pend_valid   <= 1'b0;
      valid        <= '0;
      vertex_count <= 4'd8;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (clr_all) begin
        valid <= '0;
      end else if (valid_set) begin
        valid[addr_q] <= 1'b1;
      end else if (valid_clr) begin
        valid[addr_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_q <= rd_addr;
    row_q  <= row_next;
    col_q  <= col_next;
    if (s_tvalid && s_tready) begin
      op_q  <= s_tdata[2:0];
      src_q <= in_src;
      dst_q <= in_dst;
      wgt_q <= s_tdata[42:11];
    end
    if (pend_load) begin
      pend_src <= VNUM_W'(row_q) + 4'd1;
      pend_dst <= VNUM_W'(col_q) + 4'd1;
      pend_wgt <= entry_word;
    end
    if (emit) begin
      out_q <= emit_res;
    end
  end

  assign m_tdata = {3'b000, out_q.edge_weight, out_q.edge_dest, out_q.edge_source,
                    out_q.found, out_q.adjacent, out_q.status};
  assign m_tlast = out_q.last;

  `AMS_ASSERT_NOW(a_pend_in_scan, pend_valid,
                  state == ST_SCAN || state == ST_FLUSH,
                  "held edge outside a list operation")
  `AMS_ASSERT_NEXT(a_add_marks_valid, ram_we, valid[$past(addr_q)],
                   "added entry not marked written")
  `AMS_ASSERT_NEXT(a_clear_empties, clr_all, valid == '0,
                   "clear left written entries")
  `AMS_ASSERT_NOW(a_found_ok, m_tvalid && out_q.found,
                  out_q.status == STS_OK && !out_q.adjacent,
                  "listed edge carries a bad status")

endmodule
`default_nettype wire

// ----- hdl/ams_ram.sv -----
`default_nettype none
module ams_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import ams_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          SETTLE      = 12;   // quiet cycles before a config write
  localparam int          TAIL        = 80;   // longest list scan plus margin
  localparam logic [2:0]  OP_SPARE_6  = 3'd6;
  localparam logic [2:0]  OP_SPARE_7  = 3'd7;

  typedef enum logic [1:0] {
    K_OP,
    K_CFG,
    K_PAUSE
  } entry_kind_t;

  typedef struct {
    entry_kind_t  kind;
    logic [2:0]   op;
    logic [3:0]   src;
    logic [3:0]   dst;
    logic [31:0]  wgt;
    logic [3:0]   cfg_val;
  } backlog_entry_t;

  typedef struct {
    status_t      status;
    logic         adjacent;
    logic         found;
    logic [3:0]   edge_src;
    logic [3:0]   edge_dst;
    logic [31:0]  edge_wgt;
    logic         last;
  } graph_result_t;

  logic         clk;
  logic         rst       = 1'b1;
  logic         cfg_we    = 1'b0;
  logic [3:0]   cfg_wdata = 4'd0;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata   = 48'd0;
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [47:0]  m_tdata;
  logic         m_tlast;

  backlog_entry_t  op_backlog[$];
  graph_result_t   graph_op_results[$];
  backlog_entry_t  in_flight;

  // predictor copy of the matrix and register
  logic [31:0]  weight_mem [DEPTH];
  logic [3:0]   vertex_limit;

  int  ops_accepted   = 0;
  int  results_seen   = 0;
  int  list_results   = 0;
  int  cfg_writes     = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  int  settle_count   = 0;

  adjacency_matrix_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] active_vertices();
    return (vertex_limit > MAX_VERTICES) ? 4'(MAX_VERTICES) : vertex_limit;
  endfunction

  function automatic logic vertex_ok(logic [3:0] v);
    return (v >= 4'd1) && (v <= active_vertices());
  endfunction

  function automatic int cell_of(logic [3:0] s, logic [3:0] d);
    return (int'(s) - 1) * MAX_VERTICES + (int'(d) - 1);
  endfunction

  task automatic push_result(status_t st, logic adj, logic fnd, logic [3:0] es,
                             logic [3:0] ed, logic [31:0] ew);
    graph_result_t r;
    r.status   = st;
    r.adjacent = adj;
    r.found    = fnd;
    r.edge_src = es;
    r.edge_dst = ed;
    r.edge_wgt = ew;
    r.last     = 1'b0;
    graph_op_results.insert(graph_op_results.size(), r);
  endtask

  task automatic clear_matrix();
    for (int i = 0; i < DEPTH; i++) weight_mem[i] = EMPTY_WORD;
  endtask

  // Apply one operation to the local matrix and queue the results it yields.
  task automatic run_graph_op(backlog_entry_t it);
    logic [3:0] n;
    int         emitted;
    n = active_vertices();
    emitted = 0;
    case (it.op)
      OP_ADD: begin
        if (!vertex_ok(it.src) || !vertex_ok(it.dst))
          push_result(STS_INVALID, 0, 0, 0, 0, 0);
        else if (it.src == it.dst)
          push_result(STS_SELF, 0, 0, 0, 0, 0);
        else if (weight_mem[cell_of(it.src, it.dst)] != EMPTY_WORD)
          push_result(STS_PARALLEL, 0, 0, 0, 0, 0);
        else begin
          weight_mem[cell_of(it.src, it.dst)] = it.wgt;
          push_result(STS_OK, 0, 0, 0, 0, 0);
        end
      end
      OP_REMOVE: begin
        if (!vertex_ok(it.src) || !vertex_ok(it.dst))
          push_result(STS_INVALID, 0, 0, 0, 0, 0);
        else if (weight_mem[cell_of(it.src, it.dst)] == EMPTY_WORD)
          push_result(STS_NO_EDGE, 0, 0, 0, 0, 0);
        else begin
          weight_mem[cell_of(it.src, it.dst)] = EMPTY_WORD;
          push_result(STS_OK, 0, 0, 0, 0, 0);
        end
      end
      OP_QUERY: begin
        if (!vertex_ok(it.src) || !vertex_ok(it.dst))
          push_result(STS_INVALID, 0, 0, 0, 0, 0);
        else
          push_result(STS_OK, weight_mem[cell_of(it.src, it.dst)] != EMPTY_WORD,
                      0, 0, 0, 0);
      end
      OP_LIST_NBR: begin
        if (!vertex_ok(it.src))
          push_result(STS_INVALID, 0, 0, 0, 0, 0);
        else begin
          for (int j = 1; j <= int'(n); j++)
            if (weight_mem[cell_of(it.src, 4'(j))] != EMPTY_WORD) begin
              push_result(STS_OK, 0, 1, it.src, 4'(j), weight_mem[cell_of(it.src, 4'(j))]);
              emitted++;
            end
          if (emitted == 0) push_result(STS_OK, 0, 0, 0, 0, 0);
        end
      end
      OP_LIST_ALL: begin
        for (int i = 1; i <= int'(n); i++)
          for (int j = 1; j <= int'(n); j++)
            if (weight_mem[cell_of(4'(i), 4'(j))] != EMPTY_WORD) begin
              push_result(STS_OK, 0, 1, 4'(i), 4'(j), weight_mem[cell_of(4'(i), 4'(j))]);
              emitted++;
            end
        if (emitted == 0) push_result(STS_OK, 0, 0, 0, 0, 0);
      end
      OP_CLEAR: begin
        clear_matrix();
        push_result(STS_OK, 0, 0, 0, 0, 0);
      end
      default: push_result(STS_OK, 0, 0, 0, 0, 0);
    endcase
    list_results += emitted;
    graph_op_results[graph_op_results.size() - 1].last = 1'b1;
  endtask

  // Idle and stall rates rotate every 30 accepted operations.
  function automatic int send_idle_pct();
    case ((ops_accepted / 30) % 4)
      1:       return 88;
      3:       return 16;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case ((ops_accepted / 30) % 4)
      2:       return 88;
      3:       return 16;
      default: return 0;
    endcase
  endfunction

  // Driver: present backlog operations, hold config writes until the block drains.
  always @(posedge clk) begin : drv
    logic next_valid;
    logic next_we;
    next_valid = 1'b0;
    next_we    = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        run_graph_op(in_flight);
        ops_accepted++;
      end
      if (s_tvalid && !s_tready) begin
        next_valid = 1'b1;   // hold until the transfer completes
      end else if (op_backlog.size() > 0) begin
        if (graph_op_results.size() != 0) settle_count = 0;
        case (op_backlog[0].kind)
          K_CFG: begin
            if (graph_op_results.size() == 0) begin
              settle_count++;
              if (settle_count >= SETTLE) begin
                next_we      = 1'b1;
                cfg_wdata   <= op_backlog[0].cfg_val;
                vertex_limit = op_backlog[0].cfg_val;
                cfg_writes++;
                settle_count = 0;
                void'(op_backlog.pop_front());
              end
            end
          end
          K_PAUSE: begin
            if (graph_op_results.size() == 0) void'(op_backlog.pop_front());
          end
          default: begin
            if ($urandom_range(99) >= send_idle_pct()) begin
              in_flight  = op_backlog.pop_front();
              s_tdata   <= {5'd0, in_flight.wgt, in_flight.dst, in_flight.src,
                            in_flight.op};
              next_valid = 1'b1;
            end
          end
        endcase
      end
    end
    s_tvalid <= next_valid;
    cfg_we   <= next_we;
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Monitor: compare every result transfer against the oldest prediction.
  always @(posedge clk) begin : mon
    graph_result_t exp_r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (graph_op_results.size() == 0) begin
          $error("unexpected result transfer: tdata %h tlast %b", m_tdata, m_tlast);
          mismatches++;
        end else begin
          exp_r = graph_op_results.pop_front();
          check_field("status",      32'(exp_r.status),   32'(m_tdata[2:0]));
          check_field("adjacent",    32'(exp_r.adjacent), 32'(m_tdata[3]));
          check_field("found",       32'(exp_r.found),    32'(m_tdata[4]));
          check_field("edge_source", 32'(exp_r.edge_src), 32'(m_tdata[8:5]));
          check_field("edge_dest",   32'(exp_r.edge_dst), 32'(m_tdata[12:9]));
          check_field("edge_weight", exp_r.edge_wgt,      m_tdata[44:13]);
          check_field("last",        32'(exp_r.last),     32'(m_tlast));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, graph_op_results.size());
      $display("adjacency_matrix_store verification failed");
      $finish;
    end
  end

  task automatic queue_op(logic [2:0] op, logic [3:0] s, logic [3:0] d, logic [31:0] w);
    backlog_entry_t e;
    e.kind    = K_OP;
    e.op      = op;
    e.src     = s;
    e.dst     = d;
    e.wgt     = w;
    e.cfg_val = 4'd0;
    op_backlog.insert(op_backlog.size(), e);
  endtask

  task automatic queue_marker(entry_kind_t k, logic [3:0] v);
    backlog_entry_t e;
    e.kind    = k;
    e.op      = OP_CLEAR;
    e.src     = 4'd0;
    e.dst     = 4'd0;
    e.wgt     = 32'd0;
    e.cfg_val = v;
    op_backlog.insert(op_backlog.size(), e);
  endtask

  function automatic logic [3:0] pick_vertex(int act);
    if (act == 0 || $urandom_range(99) < 8)
      return ($urandom_range(1) != 0 || act >= 15) ? 4'd0 : 4'($urandom_range(15, act + 1));
    return 4'($urandom_range(act, 1));
  endfunction

  // Mostly well-formed traffic on valid vertices, with some invalid and spare codes.
  task automatic queue_random_op(int act);
    int          roll;
    logic [2:0]  op;
    logic [3:0]  s;
    logic [3:0]  d;
    logic [31:0] w;
    roll = $urandom_range(99);
    if      (roll < 40) op = OP_ADD;
    else if (roll < 60) op = OP_REMOVE;
    else if (roll < 75) op = OP_QUERY;
    else if (roll < 85) op = OP_LIST_NBR;
    else if (roll < 92) op = OP_LIST_ALL;
    else if (roll < 95) op = OP_CLEAR;
    else                op = ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
    s = pick_vertex(act);
    d = ($urandom_range(99) < 10) ? s : pick_vertex(act);
    case ($urandom_range(19))
      0:       w = EMPTY_WORD;
      1:       w = 32'h0000_0000;
      2:       w = 32'hFFFF_FFFF;
      default: w = $urandom();
    endcase
    queue_op(op, s, d, w);
  endtask

  initial begin
    int          op_total;
    logic [3:0]  settings [9];
    int          act;
    settings = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd1, 4'd2, 4'd6, 4'd9, 4'd8};
    vertex_limit = 4'd8;
    clear_matrix();

    // directed part at the reset vertex count of eight
    queue_op(OP_LIST_ALL, 0, 0, 0);
    queue_op(OP_LIST_NBR, 1, 0, 0);
    queue_op(OP_ADD,      1, 2, 32'hFFFF_FFFF);
    queue_op(OP_ADD,      8, 1, 32'h0000_0000);
    queue_op(OP_ADD,      1, 8, 32'hA5A5_5A5A);
    queue_op(OP_ADD,      1, 1, 32'h1234_5678);
    queue_op(OP_ADD,      0, 3, 32'h1);
    queue_op(OP_ADD,      3, 15, 32'h2);
    queue_op(OP_ADD,      1, 2, 32'h3F80_0000);
    queue_op(OP_ADD,      2, 3, EMPTY_WORD);
    queue_op(OP_QUERY,    2, 3, 0);
    queue_op(OP_QUERY,    1, 2, 0);
    queue_op(OP_QUERY,    0, 15, 32'hFFFF_FFFF);
    queue_op(OP_REMOVE,   2, 3, 0);
    queue_op(OP_REMOVE,   15, 1, 0);
    queue_op(OP_REMOVE,   8, 1, 0);
    queue_op(OP_LIST_NBR, 1, 0, 0);
    queue_op(OP_LIST_NBR, 0, 5, 0);
    queue_op(OP_LIST_NBR, 15, 0, 0);
    queue_op(OP_SPARE_6,  15, 15, 32'hFFFF_FFFF);
    queue_op(OP_SPARE_7,  2, 1, 32'h5555_AAAA);
    queue_op(OP_LIST_ALL, 9, 9, 0);
    queue_op(OP_CLEAR,    0, 0, 0);
    queue_op(OP_LIST_ALL, 0, 0, 0);
    queue_op(OP_ADD,      1, 8, 32'hC0DE_0001);
    queue_marker(K_PAUSE, 0);

    // random part: one block of traffic per vertex count, without clearing in between
    foreach (settings[i]) begin
      queue_marker(K_CFG, settings[i]);
      act = (settings[i] > MAX_VERTICES) ? MAX_VERTICES : int'(settings[i]);
      for (int k = 0; k < 45; k++) begin
        if (k == 22) queue_marker(K_PAUSE, 0);
        queue_random_op(act);
      end
      queue_op(OP_LIST_ALL, 0, 0, 0);
    end

    op_total = 0;
    foreach (op_backlog[i]) if (op_backlog[i].kind == K_OP) op_total++;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (op_backlog.size() != 0 || s_tvalid || graph_op_results.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("ran %0d of %0d operations over %0d vertex-count writes; checked %0d results,",
             ops_accepted, op_total, cfg_writes, results_seen);
    $display("%0d of them listed edges; %0d field mismatches", list_results, mismatches);
    if (mismatches == 0 && graph_op_results.size() == 0)
      $display("adjacency_matrix_store verification clean");
    else
      $display("adjacency_matrix_store verification failed");
    $finish;
  end

endmodule
